// ===== src/npls_pkg.sv =====
// ----------------------------------------------------------------------------
// npls_pkg
// Shared types, sizes and helpers for the nearest point load sizer.
// ----------------------------------------------------------------------------
package npls_pkg;

  // Table and class sizes
  localparam int MAX_POINTS   = 1024;
  localparam int SIZE_CLASSES = 6;
  localparam int ADDR_W       = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CNT_W        = $clog2(MAX_POINTS + 1);

  // Field widths
  localparam int ACT_W   = 2;
  localparam int IDX_W   = 10;
  localparam int COORD_W = 30;
  localparam int LOAD_W  = 32;
  localparam int CLS_W   = 3;
  localparam int SQ_W    = 2 * COORD_W;
  localparam int DIST_W  = SQ_W + 1;

  // Register file
  localparam int NUM_REGS    = 1 + SIZE_CLASSES;
  localparam int REG_IDX_W   = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
  localparam int CFG_ADDR_W  = REG_IDX_W + 2;
  localparam int CFG_DATA_W  = 32;
  localparam int REG_CLASSES = 0;
  localparam int REG_LIMIT0  = 1;

  // Front to back queue
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  // Action codes on the input channel
  localparam logic [ACT_W-1:0] ACT_LOAD  = ACT_W'(0);
  localparam logic [ACT_W-1:0] ACT_SINK  = ACT_W'(1);
  localparam logic [ACT_W-1:0] ACT_QUERY = ACT_W'(2);

  // Classified operation handed to the back end
  typedef enum logic [1:0] {
    OP_LOAD,
    OP_SINK,
    OP_QUERY,
    OP_SKIP
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [IDX_W-1:0]   idx;
    logic [COORD_W-1:0] cx;
    logic [COORD_W-1:0] cy;
    logic [LOAD_W-1:0]  cap;
  } item_t;

  typedef struct packed {
    logic [IDX_W-1:0]  nearest_index;
    logic [LOAD_W-1:0] total_load;
    logic [CLS_W-1:0]  size_choice;
    logic              overloaded;
    logic              no_points;
  } result_t;

  typedef struct packed {
    logic [CLS_W-1:0]                     n_classes;
    logic [SIZE_CLASSES-1:0][LOAD_W-1:0]  limit;
  } cfg_t;

  // Saturating unsigned add
  function automatic logic [LOAD_W-1:0] sat_add(input logic [LOAD_W-1:0] a,
                                                input logic [LOAD_W-1:0] b);
    logic [LOAD_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[LOAD_W] ? {LOAD_W{1'b1}} : s[LOAD_W-1:0];
  endfunction

  function automatic logic idx_in_range(input logic [IDX_W-1:0] idx);
    return 32'(idx) < 32'(MAX_POINTS);
  endfunction

  function automatic logic [ADDR_W-1:0] idx_to_addr(input logic [IDX_W-1:0] idx);
    logic [ADDR_W+IDX_W-1:0] w;
    w = {ADDR_W'(0), idx};
    return w[ADDR_W-1:0];
  endfunction

  function automatic logic [IDX_W-1:0] addr_to_idx(input logic [ADDR_W-1:0] a);
    logic [ADDR_W+IDX_W-1:0] w;
    w = {IDX_W'(0), a};
    return w[IDX_W-1:0];
  endfunction

endpackage

// ===== src/npls_if.sv =====
// ----------------------------------------------------------------------------
// npls_if
// Valid/ready channel interfaces for input items and results.
// ----------------------------------------------------------------------------
interface npls_in_if
  import npls_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [ACT_W-1:0]   action;
  logic [IDX_W-1:0]   point_index;
  logic [COORD_W-1:0] coord_x;
  logic [COORD_W-1:0] coord_y;
  logic [LOAD_W-1:0]  cap_value;

  modport source (output valid, action, point_index, coord_x, coord_y, cap_value,
                  input ready);
  modport sink   (input valid, action, point_index, coord_x, coord_y, cap_value,
                  output ready);
endinterface

interface npls_out_if
  import npls_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [IDX_W-1:0]  nearest_index;
  logic [LOAD_W-1:0] total_load;
  logic [CLS_W-1:0]  size_choice;
  logic              overloaded;
  logic              no_points;

  modport source (output valid, nearest_index, total_load, size_choice, overloaded,
                  no_points, input ready);
  modport sink   (input valid, nearest_index, total_load, size_choice, overloaded,
                  no_points, output ready);
endinterface

// ===== src/nearest_point_load_sizer.sv =====
// ----------------------------------------------------------------------------
// nearest_point_load_sizer
// Grid point table with nearest point sink assignment and buffer sizing.
// ----------------------------------------------------------------------------
// Items arrive on in_item (valid/ready): load writes a grid point and clears
// its sink sum, sink adds a pin load to the nearest stored point, query
// returns a point's total load and the chosen size class. Every item gives
// exactly one result on out_item (valid/ready). The user must set class count
// and limits over APB only while the block is idle; it does not enforce this.
// A two-entry queue sits between the input and the execution engine, so
// items are taken while a result waits in the output register.
// A sink scans for the nearest point: it reads one stored point per cycle
// from the coordinate memory and then drains a three-stage square-and-sum
// pipeline. A sink on an empty table skips the scan.
// Reset empties the table (no clearing pass), sets the class count to one
// and all limits to zero. A stalled receiver holds the result; the engine
// then waits and the queue fills before in_item.ready drops.
// ----------------------------------------------------------------------------
module nearest_point_load_sizer
  import npls_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  npls_in_if.sink               in_item,
  npls_out_if.source            out_item,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  cfg_t  cfg_w;
  item_t q_item;
  logic  q_valid;
  logic  q_pop;

  // configuration registers
  npls_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg_w)
  );

  // accept, classify, queue
  npls_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_item (in_item),
    .q_item  (q_item),
    .q_valid (q_valid),
    .q_pop   (q_pop)
  );

  // execution engine
  npls_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_item   (q_item),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .cfg      (cfg_w),
    .out_item (out_item)
  );

`ifndef SYNTHESIS
  // engine takes only from a non-empty queue
  a_pop_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

  // engine never takes items in back-to-back cycles
  a_no_double_pop: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> !q_pop)
    else $error("queue popped on consecutive cycles");

  // overload always selects the largest class in use
  a_over_largest: assert property (@(posedge clk) disable iff (!rst_n)
    out_item.valid && out_item.overloaded |->
      out_item.size_choice == cfg_w.n_classes - CLS_W'(1))
    else $error("overloaded result without largest class");

  // an ignored sink carries no load or size
  a_empty_sink: assert property (@(posedge clk) disable iff (!rst_n)
    out_item.valid && out_item.no_points |->
      out_item.total_load == '0 && out_item.size_choice == '0 && !out_item.overloaded)
    else $error("empty table result carries data");
`endif

endmodule

// ===== src/npls_cfg.sv =====
// ----------------------------------------------------------------------------
// npls_cfg
// APB register file: size class count and per-class load limits.
// ----------------------------------------------------------------------------
module npls_cfg
  import npls_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  logic [CLS_W-1:0]  classes_r;
  logic [LOAD_W-1:0] limit_r [SIZE_CLASSES];
  logic [REG_IDX_W-1:0] reg_idx;
  logic              wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[CFG_ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite && pready;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      classes_r <= CLS_W'(1);
      for (int k = 0; k < SIZE_CLASSES; k++) begin
        limit_r[k] <= '0;
      end
    end else if (wr_en) begin
      if (reg_idx == REG_IDX_W'(REG_CLASSES)) begin
        classes_r <= pwdata[CLS_W-1:0];
      end
      for (int k = 0; k < SIZE_CLASSES; k++) begin
        if (reg_idx == REG_IDX_W'(REG_LIMIT0 + k)) begin
          limit_r[k] <= pwdata[LOAD_W-1:0];
        end
      end
    end
  end

  // read back
  always_comb begin
    prdata = '0;
    if (reg_idx == REG_IDX_W'(REG_CLASSES)) begin
      prdata = CFG_DATA_W'(classes_r);
    end
    for (int k = 0; k < SIZE_CLASSES; k++) begin
      if (reg_idx == REG_IDX_W'(REG_LIMIT0 + k)) begin
        prdata = CFG_DATA_W'(limit_r[k]);
      end
    end
  end

  // class count clamped to 1..SIZE_CLASSES
  always_comb begin
    if (classes_r == '0) begin
      cfg.n_classes = CLS_W'(1);
    end else if (classes_r > CLS_W'(SIZE_CLASSES)) begin
      cfg.n_classes = CLS_W'(SIZE_CLASSES);
    end else begin
      cfg.n_classes = classes_r;
    end
    for (int k = 0; k < SIZE_CLASSES; k++) begin
      cfg.limit[k] = limit_r[k];
    end
  end

endmodule

// ===== src/npls_front.sv =====
// ----------------------------------------------------------------------------
// npls_front
// Accepts input items, classifies them and holds them in a short queue.
// ----------------------------------------------------------------------------
module npls_front
  import npls_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  npls_in_if.sink in_item,
  output item_t q_item,
  output logic  q_valid,
  input  logic  q_pop
);

  item_t             cls_item;
  item_t             q_mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic              push;

  assign in_item.ready = (count_r != QCNT_W'(QUEUE_DEPTH));
  assign push          = in_item.valid && in_item.ready;
  assign q_valid       = (count_r != '0);
  assign q_item        = q_mem_r[rd_ptr_r];

  // classify: out-of-range slots and unused actions become skips
  always_comb begin
    cls_item.idx = in_item.point_index;
    cls_item.cx  = in_item.coord_x;
    cls_item.cy  = in_item.coord_y;
    cls_item.cap = in_item.cap_value;
    unique case (in_item.action)
      ACT_LOAD:  cls_item.op = idx_in_range(in_item.point_index) ? OP_LOAD : OP_SKIP;
      ACT_SINK:  cls_item.op = OP_SINK;
      ACT_QUERY: cls_item.op = idx_in_range(in_item.point_index) ? OP_QUERY : OP_SKIP;
      default: begin
        cls_item.op  = OP_SKIP;
        cls_item.idx = '0;
      end
    endcase
  end

  // queue pointers and fill
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
      end
      if (q_pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
      end
      unique case ({push, q_pop})
        2'b10:   count_r <= count_r + QCNT_W'(1);
        2'b01:   count_r <= count_r - QCNT_W'(1);
        default: count_r <= count_r;
      endcase
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= cls_item;
    end
  end

endmodule

// ===== src/npls_back.sv =====
// ----------------------------------------------------------------------------
// npls_back
// Point table, nearest point scan, load accumulation and size selection.
// ----------------------------------------------------------------------------
module npls_back
  import npls_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  item_t q_item,
  input  logic  q_valid,
  output logic  q_pop,
  input  cfg_t  cfg,
  npls_out_if.source out_item
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_SRD,
    S_SADD,
    S_STOT,
    S_QRD,
    S_QADD,
    S_QCLS,
    S_OUT
  } state_t;

  // point table
  logic [COORD_W-1:0] mem_x [MAX_POINTS];
  logic [COORD_W-1:0] mem_y [MAX_POINTS];
  logic [LOAD_W-1:0]  mem_w [MAX_POINTS];
  logic [LOAD_W-1:0]  mem_s [MAX_POINTS];

  state_t             state_r;
  item_t              cur_r;
  logic [ADDR_W-1:0]  addr_r;
  logic [CNT_W-1:0]   points_r;
  logic [CNT_W-1:0]   scan_cnt_r;
  logic [DIST_W-1:0]  best_r;
  logic [ADDR_W-1:0]  best_i_r;
  logic [LOAD_W-1:0]  sum_r;
  logic [LOAD_W-1:0]  total_r;
  result_t            res_r;
  result_t            out_data_r;
  logic               out_valid_r;

  // scan pipeline
  logic               v1_r, v2_r, v3_r;
  logic [ADDR_W-1:0]  i1_r, i2_r, i3_r;
  logic [COORD_W-1:0] rx_r, ry_r;
  logic [SQ_W-1:0]    dx2_r, dy2_r;
  logic [DIST_W-1:0]  d2_r;
  logic [COORD_W-1:0] dx, dy;

  // w/s read data
  logic [LOAD_W-1:0]  rw_r, rs_r;

  logic               load_we;
  logic [ADDR_W-1:0]  load_addr;
  logic [CNT_W-1:0]   load_cnt;
  logic               s_we;
  logic [ADDR_W-1:0]  s_waddr;
  logic [LOAD_W-1:0]  s_wdata;
  logic [LOAD_W-1:0]  sum_nxt;
  logic               xy_re;
  logic [ADDR_W-1:0]  scan_addr;
  logic               ws_re;
  logic               cls_found;
  logic [CLS_W-1:0]   cls_pick;

  assign q_pop     = (state_r == S_IDLE) && q_valid;
  assign load_we   = q_pop && (q_item.op == OP_LOAD);
  assign load_addr = idx_to_addr(q_item.idx);
  assign load_cnt  = CNT_W'(load_addr) + CNT_W'(1);
  assign sum_nxt   = sat_add(rs_r, cur_r.cap);
  assign xy_re     = (state_r == S_SCAN) && (scan_cnt_r < points_r);
  assign scan_addr = scan_cnt_r[ADDR_W-1:0];
  assign ws_re     = (state_r == S_SRD) || (state_r == S_QRD);

  // sink sum written by a load (cleared) or by a sink update
  always_comb begin
    if (load_we) begin
      s_we    = 1'b1;
      s_waddr = load_addr;
      s_wdata = '0;
    end else begin
      s_we    = (state_r == S_SADD);
      s_waddr = addr_r;
      s_wdata = sum_nxt;
    end
  end

  // coordinate memories
  always_ff @(posedge clk) begin
    if (load_we) begin
      mem_x[load_addr] <= q_item.cx;
      mem_y[load_addr] <= q_item.cy;
    end
    if (xy_re) begin
      rx_r <= mem_x[scan_addr];
      ry_r <= mem_y[scan_addr];
    end
  end

  // wire load memory
  always_ff @(posedge clk) begin
    if (load_we) begin
      mem_w[load_addr] <= q_item.cap;
    end
    if (ws_re) begin
      rw_r <= mem_w[addr_r];
    end
  end

  // sink sum memory
  always_ff @(posedge clk) begin
    if (s_we) begin
      mem_s[s_waddr] <= s_wdata;
    end
    if (ws_re) begin
      rs_r <= mem_s[addr_r];
    end
  end

  // distance terms
  always_comb begin
    dx = (rx_r >= cur_r.cx) ? rx_r - cur_r.cx : cur_r.cx - rx_r;
    dy = (ry_r >= cur_r.cy) ? ry_r - cur_r.cy : cur_r.cy - ry_r;
  end

  // scan pipeline valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= xy_re;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // scan pipeline data: read, square, sum
  always_ff @(posedge clk) begin
    i1_r  <= scan_addr;
    i2_r  <= i1_r;
    i3_r  <= i2_r;
    dx2_r <= SQ_W'(dx) * SQ_W'(dx);
    dy2_r <= SQ_W'(dy) * SQ_W'(dy);
    d2_r  <= {1'b0, dx2_r} + {1'b0, dy2_r};
  end

  // smallest class whose limit covers the load
  always_comb begin
    cls_found = 1'b0;
    cls_pick  = cfg.n_classes - CLS_W'(1);
    for (int k = SIZE_CLASSES - 1; k >= 0; k--) begin
      if ((CLS_W'(k) < cfg.n_classes) && (cfg.limit[k] >= total_r)) begin
        cls_found = 1'b1;
        cls_pick  = CLS_W'(k);
      end
    end
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      points_r    <= '0;
      scan_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_item.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            cur_r <= q_item;
            unique case (q_item.op)
              OP_LOAD: begin
                if (load_cnt > points_r) begin
                  points_r <= load_cnt;
                end
                res_r   <= '{q_item.idx, q_item.cap, CLS_W'(0), 1'b0, 1'b0};
                state_r <= S_OUT;
              end
              OP_SINK: begin
                if (points_r == '0) begin
                  res_r   <= '{IDX_W'(0), LOAD_W'(0), CLS_W'(0), 1'b0, 1'b1};
                  state_r <= S_OUT;
                end else begin
                  scan_cnt_r <= '0;
                  best_r     <= '1;
                  best_i_r   <= '0;
                  state_r    <= S_SCAN;
                end
              end
              OP_QUERY: begin
                addr_r  <= load_addr;
                state_r <= S_QRD;
              end
              OP_SKIP: begin
                res_r   <= '{q_item.idx, LOAD_W'(0), CLS_W'(0), 1'b0, 1'b0};
                state_r <= S_OUT;
              end
              default: state_r <= S_IDLE;
            endcase
          end
        end
        S_SCAN: begin
          if (xy_re) begin
            scan_cnt_r <= scan_cnt_r + CNT_W'(1);
          end
          // strict compare keeps the lowest index on a tie
          if (v3_r && (d2_r < best_r)) begin
            best_r   <= d2_r;
            best_i_r <= i3_r;
          end
          if (!xy_re && !v1_r && !v2_r && !v3_r) begin
            addr_r  <= best_i_r;
            state_r <= S_SRD;
          end
        end
        S_SRD: state_r <= S_SADD;
        S_SADD: begin
          sum_r   <= sum_nxt;
          state_r <= S_STOT;
        end
        S_STOT: begin
          res_r   <= '{addr_to_idx(addr_r), sat_add(rw_r, sum_r), CLS_W'(0), 1'b0, 1'b0};
          state_r <= S_OUT;
        end
        S_QRD: state_r <= S_QADD;
        S_QADD: begin
          total_r <= sat_add(rw_r, rs_r);
          state_r <= S_QCLS;
        end
        S_QCLS: begin
          res_r   <= '{cur_r.idx, total_r, cls_pick, !cls_found, 1'b0};
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_r || out_item.ready) begin
            out_valid_r <= 1'b1;
            out_data_r  <= res_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_item.valid         = out_valid_r;
  assign out_item.nearest_index = out_data_r.nearest_index;
  assign out_item.total_load    = out_data_r.total_load;
  assign out_item.size_choice   = out_data_r.size_choice;
  assign out_item.overloaded    = out_data_r.overloaded;
  assign out_item.no_points     = out_data_r.no_points;

endmodule
